### src/pfac_pkg.sv
// ----------------------------------------------------------------------------
// pfac_pkg
// Shared widths, types and register codes of the face angle check pipeline.
// ----------------------------------------------------------------------------
package pfac_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int BOX_W       = 31;
   localparam int COS_W       = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;

   // Edge difference and wrapped edge widths.
   localparam int DW     = COORD_WIDTH + 1;
   localparam int EW     = ((DW > BOX_W) ? DW : BOX_W) + 2;
   localparam int ES_MAX = EW - 30;
   localparam int ES_W   = $clog2(ES_MAX + 1);

   // Cross product, normal scaling and unit length stages.
   localparam int EDGE_LOG     = 30;
   localparam int NORM_LOW_LOG = 30;
   localparam int PW           = 32;
   localparam int NW           = 64;
   localparam int NSW          = 33;
   localparam int SHAMT_W      = 6;
   localparam int MAGW         = 32;
   localparam int SQW          = 64;
   localparam int ROOTW        = 32;
   localparam int REMW         = 66;
   localparam int SQRT_STAGES  = ROOTW;
   localparam int FRAC_Q14     = 14;
   localparam int NUMW         = MAGW + FRAC_Q14;
   localparam int QW           = 15;
   localparam int DIV_STAGES   = QW;
   localparam int UNIT_Q14     = 16384;
   localparam int ROUND_BIAS   = 8192;
   localparam int DOT_W        = 32;

   localparam logic [BOX_W-1:0] BOX_RESET = BOX_W'(655360);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BOX_X   = 2'd0,
      CSR_BOX_Y   = 2'd1,
      CSR_BOX_Z   = 2'd2,
      CSR_MIN_COS = 2'd3
   } csr_index_type;

   typedef logic signed [COORD_WIDTH-1:0] coord_vec_type [3];
   typedef logic [BOX_W-1:0]              box_vec_type [3];
   typedef logic signed [EW-1:0]          edge_vec_type [3];

   typedef struct packed {
      logic                     valid;
      logic                     zero;
      logic [2:0][COS_W-1:0]    u;
   } face_out_type;

endpackage

### src/pfac_ifs.sv
// ----------------------------------------------------------------------------
// pfac channel interfaces
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pfac_req_if;
   import pfac_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] a_x, a_y, a_z;
   logic signed [COORD_WIDTH-1:0] b_x, b_y, b_z;
   logic signed [COORD_WIDTH-1:0] c_x, c_y, c_z;
   logic signed [COORD_WIDTH-1:0] d_x, d_y, d_z;
   modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z,
                   c_x, c_y, c_z, d_x, d_y, d_z, input ready);
   modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z,
                   c_x, c_y, c_z, d_x, d_y, d_z, output ready);
endinterface

interface pfac_rsp_if;
   import pfac_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    angle_ok;
   logic signed [COS_W-1:0] normal_cosine;
   logic                    degenerate;
   modport source (output valid, angle_ok, normal_cosine, degenerate, input ready);
   modport sink   (input valid, angle_ok, normal_cosine, degenerate, output ready);
endinterface

interface pfac_csr_if;
   import pfac_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### src/pfac_wrap.sv
// ----------------------------------------------------------------------------
// pfac_wrap
// Two-stage edge builder: differences, then one minimum-image shift per axis.
// ----------------------------------------------------------------------------
module pfac_wrap (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  pfac_pkg::coord_vec_type a,
   input  pfac_pkg::coord_vec_type b,
   input  pfac_pkg::coord_vec_type c,
   input  pfac_pkg::coord_vec_type d,
   input  pfac_pkg::box_vec_type   box,
   output logic                   out_valid,
   output pfac_pkg::edge_vec_type  eb,
   output pfac_pkg::edge_vec_type  ec,
   output pfac_pkg::edge_vec_type  ed
);
   import pfac_pkg::*;

   logic [1:0]           vld_ff;
   logic signed [DW-1:0] db_ff [3], dc_ff [3], dd_ff [3];
   logic signed [DW-1:0] db_in [3], dc_in [3], dd_in [3];
   edge_vec_type         eb_ff, ec_ff, ed_ff, eb_in, ec_in, ed_in;

   // A component longer than half the box is moved by one box length.
   function automatic logic signed [EW-1:0] wrap_axis(input logic signed [DW-1:0] dv,
                                                      input logic [BOX_W-1:0] bl);
      logic signed [EW-1:0] dx;
      logic signed [EW-1:0] bs;
      logic [EW-1:0]        mg;
      logic [EW:0]          twice;
      dx    = EW'(dv);
      bs    = signed'(EW'(bl));
      mg    = dx[EW-1] ? EW'(-dx) : EW'(dx);
      twice = {mg, 1'b0};
      if (twice > (EW+1)'(bl)) begin
         if (dx < 0) begin
            dx = dx + bs;
         end else if (dx > 0) begin
            dx = dx - bs;
         end
      end
      return dx;
   endfunction

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         db_in[k] = DW'(b[k]) - DW'(a[k]);
         dc_in[k] = DW'(c[k]) - DW'(a[k]);
         dd_in[k] = DW'(d[k]) - DW'(a[k]);
         eb_in[k] = wrap_axis(db_ff[k], box[k]);
         ec_in[k] = wrap_axis(dc_ff[k], box[k]);
         ed_in[k] = wrap_axis(dd_ff[k], box[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         db_ff <= db_in;
         dc_ff <= dc_in;
         dd_ff <= dd_in;
         eb_ff <= eb_in;
         ec_ff <= ec_in;
         ed_ff <= ed_in;
      end
   end

   assign out_valid = vld_ff[1];
   assign eb        = eb_ff;
   assign ec        = ec_ff;
   assign ed        = ed_ff;

endmodule

### src/pfac_sqrt.sv
// ----------------------------------------------------------------------------
// pfac_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module pfac_sqrt (
   input  logic                        clock,
   input  logic                        en,
   input  logic [pfac_pkg::SQW-1:0]    x,
   output logic [pfac_pkg::ROOTW-1:0]  root
);
   import pfac_pkg::*;

   logic [REMW-1:0]  rem_ff  [SQRT_STAGES];
   logic [REMW-1:0]  rem_in  [SQRT_STAGES];
   logic [ROOTW-1:0] root_ff [SQRT_STAGES];
   logic [ROOTW-1:0] root_in [SQRT_STAGES];

   // Stage j decides root bit i; trial is (root+2^i)^2 - root^2.
   always_comb begin
      logic [REMW-1:0]  rin;
      logic [ROOTW-1:0] qin;
      logic [REMW-1:0]  trial;
      for (int j = 0; j < SQRT_STAGES; j++) begin
         rin   = (j == 0) ? REMW'(x) : rem_ff[(j == 0) ? 0 : j-1];
         qin   = (j == 0) ? '0 : root_ff[(j == 0) ? 0 : j-1];
         trial = (REMW'(qin) << (ROOTW - j)) + (REMW'(1) << (2*(ROOTW-1-j)));
         if (rin >= trial) begin
            rem_in[j]  = rin - trial;
            root_in[j] = qin | (ROOTW'(1) << (ROOTW-1-j));
         end else begin
            rem_in[j]  = rin;
            root_in[j] = qin;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign root = root_ff[SQRT_STAGES-1];

endmodule

### src/pfac_div.sv
// ----------------------------------------------------------------------------
// pfac_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module pfac_div (
   input  logic                        clock,
   input  logic                        en,
   input  logic [pfac_pkg::NUMW-1:0]   num,
   input  logic [pfac_pkg::ROOTW-1:0]  den,
   output logic [pfac_pkg::QW-1:0]     quo
);
   import pfac_pkg::*;

   logic [NUMW-1:0]  rem_ff [DIV_STAGES];
   logic [NUMW-1:0]  rem_in [DIV_STAGES];
   logic [ROOTW-1:0] den_ff [DIV_STAGES];
   logic [ROOTW-1:0] den_in [DIV_STAGES];
   logic [QW-1:0]    quo_ff [DIV_STAGES];
   logic [QW-1:0]    quo_in [DIV_STAGES];

   // The quotient is known to stay below 2^QW, so the top bit starts the search.
   always_comb begin
      logic [NUMW-1:0]  rin;
      logic [ROOTW-1:0] din;
      logic [QW-1:0]    qin;
      logic [NUMW-1:0]  trial;
      for (int j = 0; j < DIV_STAGES; j++) begin
         rin   = (j == 0) ? num : rem_ff[(j == 0) ? 0 : j-1];
         din   = (j == 0) ? den : den_ff[(j == 0) ? 0 : j-1];
         qin   = (j == 0) ? '0 : quo_ff[(j == 0) ? 0 : j-1];
         trial = NUMW'(din) << (QW-1-j);
         den_in[j] = din;
         if (rin >= trial) begin
            rem_in[j] = rin - trial;
            quo_in[j] = qin | (QW'(1) << (QW-1-j));
         end else begin
            rem_in[j] = rin;
            quo_in[j] = qin;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         den_ff <= den_in;
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff[DIV_STAGES-1];

endmodule

### src/pfac_face.sv
// ----------------------------------------------------------------------------
// pfac_face
// Unit normal of one face: edge scaling, cross product, normal scaling,
// square root of the squared length and one division per component.
// ----------------------------------------------------------------------------
module pfac_face (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  pfac_pkg::edge_vec_type  e,
   input  pfac_pkg::edge_vec_type  f,
   output pfac_pkg::face_out_type  res
);
   import pfac_pkg::*;

   localparam int FRONT_STAGES = 10;
   localparam int FACE_LAT     = FRONT_STAGES + SQRT_STAGES + DIV_STAGES + 2;

   typedef struct packed {
      logic [2:0][MAGW-1:0] mag;
      logic [2:0]           neg;
      logic                 zero;
   } root_side_type;

   typedef struct packed {
      logic [2:0] neg;
      logic       zero;
   } quo_side_type;

   logic [FACE_LAT-1:0]   vld_ff;

   edge_vec_type          e1_ff, f1_ff, e2_ff, f2_ff;
   logic [EW-1:0]         m1_ff, m1_in;
   logic [ES_W-1:0]       s2_ff, s2_in;
   logic signed [PW-1:0]  p3_ff [3], q3_ff [3], p3_in [3], q3_in [3];
   logic signed [NW-1:0]  x4_ff [6], x4_in [6];
   logic signed [NW-1:0]  n5_ff [3], n5_in [3];
   logic signed [NW-1:0]  n6_ff [3];
   logic                  right6_ff, right6_in, zero6_ff, zero6_in;
   logic [SHAMT_W-1:0]    amt6_ff, amt6_in;
   logic signed [NSW-1:0] sh7_ff [3], sh7_in [3];
   logic                  zero7_ff;
   root_side_type         side8_ff, side8_in, side9_ff, side10_ff;
   logic [SQW-1:0]        sq9_ff [3], sq9_in [3];
   logic [SQW-1:0]        sum10_ff, sum10_in;
   root_side_type         rside_ff [SQRT_STAGES];
   logic [ROOTW-1:0]      root_w;
   logic [NUMW-1:0]       num11_ff [3], num11_in [3];
   logic [ROOTW-1:0]      den11_ff;
   quo_side_type          qside_ff [DIV_STAGES+1];
   logic [QW-1:0]         quo_w [3];
   logic [2:0][COS_W-1:0] u12_ff, u12_in;
   logic                  zero12_ff;

   function automatic logic [EW-1:0] edge_mag(input logic signed [EW-1:0] v);
      return v[EW-1] ? EW'(-v) : EW'(v);
   endfunction

   // Largest edge magnitude of the face.
   always_comb begin
      m1_in = '0;
      for (int k = 0; k < 3; k++) begin
         if (edge_mag(e[k]) > m1_in) m1_in = edge_mag(e[k]);
         if (edge_mag(f[k]) > m1_in) m1_in = edge_mag(f[k]);
      end
   end

   // Smallest shift that brings that magnitude to at most 2^30.
   always_comb begin
      s2_in = ES_W'(ES_MAX);
      for (int s = ES_MAX; s >= 0; s--) begin
         if ((m1_ff >> s) <= (EW'(1) << EDGE_LOG)) s2_in = ES_W'(s);
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         p3_in[k] = PW'(e2_ff[k] >>> s2_ff);
         q3_in[k] = PW'(f2_ff[k] >>> s2_ff);
      end
   end

   always_comb begin
      x4_in[0] = p3_ff[1] * q3_ff[2];
      x4_in[1] = p3_ff[2] * q3_ff[1];
      x4_in[2] = p3_ff[2] * q3_ff[0];
      x4_in[3] = p3_ff[0] * q3_ff[2];
      x4_in[4] = p3_ff[0] * q3_ff[1];
      x4_in[5] = p3_ff[1] * q3_ff[0];
      n5_in[0] = x4_ff[0] - x4_ff[1];
      n5_in[1] = x4_ff[2] - x4_ff[3];
      n5_in[2] = x4_ff[4] - x4_ff[5];
   end

   // The leading one of the OR of the magnitudes is the leading one of the
   // largest magnitude, which sets the normal scaling shift.
   always_comb begin
      logic [NW-1:0]      or_v;
      logic [SHAMT_W-1:0] pos;
      or_v = '0;
      pos  = '0;
      for (int k = 0; k < 3; k++) begin
         or_v = or_v | (n5_ff[k][NW-1] ? NW'(-n5_ff[k]) : NW'(n5_ff[k]));
      end
      for (int b = 0; b < NW; b++) begin
         if (or_v[b]) pos = SHAMT_W'(b);
      end
      zero6_in  = (or_v == '0);
      right6_in = (pos > SHAMT_W'(NORM_LOW_LOG));
      amt6_in   = right6_in ? (pos - SHAMT_W'(NORM_LOW_LOG))
                            : (SHAMT_W'(NORM_LOW_LOG) - pos);
   end

   always_comb begin
      logic signed [NW-1:0] t;
      for (int k = 0; k < 3; k++) begin
         t         = right6_ff ? (n6_ff[k] >>> amt6_ff) : (n6_ff[k] << amt6_ff);
         sh7_in[k] = t[NSW-1:0];
      end
   end

   always_comb begin
      logic signed [NSW-1:0] t;
      for (int k = 0; k < 3; k++) begin
         t                = sh7_ff[k][NSW-1] ? -sh7_ff[k] : sh7_ff[k];
         side8_in.mag[k]  = t[MAGW-1:0];
         side8_in.neg[k]  = sh7_ff[k][NSW-1];
      end
      side8_in.zero = zero7_ff;
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sq9_in[k] = side8_ff.mag[k] * side8_ff.mag[k];
      end
      sum10_in = sq9_ff[0] + sq9_ff[1] + sq9_ff[2];
   end

   pfac_sqrt u_sqrt (
      .clock (clock),
      .en    (en),
      .x     (sum10_ff),
      .root  (root_w)
   );

   // Rounded quotient: (mag * 2^14 + root / 2) / root.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         num11_in[k] = (NUMW'(rside_ff[SQRT_STAGES-1].mag[k]) << FRAC_Q14)
                     + NUMW'(root_w >> 1);
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_div
      pfac_div u_div (
         .clock (clock),
         .en    (en),
         .num   (num11_ff[g]),
         .den   (den11_ff),
         .quo   (quo_w[g])
      );
   end

   always_comb begin
      logic [QW-1:0]    q;
      logic [COS_W-1:0] a;
      for (int k = 0; k < 3; k++) begin
         q         = (quo_w[k] > QW'(UNIT_Q14)) ? QW'(UNIT_Q14) : quo_w[k];
         a         = COS_W'(q);
         u12_in[k] = qside_ff[DIV_STAGES].neg[k] ? -a : a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[FACE_LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e1_ff     <= e;
         f1_ff     <= f;
         m1_ff     <= m1_in;
         e2_ff     <= e1_ff;
         f2_ff     <= f1_ff;
         s2_ff     <= s2_in;
         p3_ff     <= p3_in;
         q3_ff     <= q3_in;
         x4_ff     <= x4_in;
         n5_ff     <= n5_in;
         n6_ff     <= n5_ff;
         right6_ff <= right6_in;
         amt6_ff   <= amt6_in;
         zero6_ff  <= zero6_in;
         sh7_ff    <= sh7_in;
         zero7_ff  <= zero6_ff;
         side8_ff  <= side8_in;
         sq9_ff    <= sq9_in;
         side9_ff  <= side8_ff;
         sum10_ff  <= sum10_in;
         side10_ff <= side9_ff;
         rside_ff[0] <= side10_ff;
         for (int j = 1; j < SQRT_STAGES; j++) begin
            rside_ff[j] <= rside_ff[j-1];
         end
         num11_ff <= num11_in;
         den11_ff <= root_w;
         qside_ff[0].neg  <= rside_ff[SQRT_STAGES-1].neg;
         qside_ff[0].zero <= rside_ff[SQRT_STAGES-1].zero;
         for (int j = 1; j <= DIV_STAGES; j++) begin
            qside_ff[j] <= qside_ff[j-1];
         end
         u12_ff    <= u12_in;
         zero12_ff <= qside_ff[DIV_STAGES].zero;
      end
   end

   // The last valid bit sits at the same depth as the unit normal registers.
   always_comb begin
      res.valid = vld_ff[FACE_LAT-1];
      res.zero  = zero12_ff;
      res.u     = u12_ff;
   end

endmodule

### src/periodic_face_angle_check.sv
// Pipeline: 63 register stages from an accepted request to its response, and
// a stall on the response side holds every stage.
// Throughput: one transaction per clock unless responses stall; the 32-stage
// square root and 15-stage divider pipelines each take an operand every cycle.
// Reset: synchronous, active high; clears all valid bits, loads box lengths of
// 10.0 and a minimum cosine of 0.
// ----------------------------------------------------------------------------
// periodic_face_angle_check
// Fold check of two triangles sharing an edge under periodic boundaries.
// ----------------------------------------------------------------------------
module periodic_face_angle_check (
   input logic         clock,
   input logic         reset,
   pfac_req_if.sink    req_chan,
   pfac_rsp_if.source  rsp_chan,
   pfac_csr_if.sink    csr_chan
);
   import pfac_pkg::*;

   // Configuration registers. Writes are taken on every cycle; the user must change
   // the register values only while no transaction is in flight; nothing enforces it.
   box_vec_type             box_ff;
   logic signed [COS_W-1:0] min_cos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff[0]  <= BOX_RESET;
         box_ff[1]  <= BOX_RESET;
         box_ff[2]  <= BOX_RESET;
         min_cos_ff <= '0;
      end else if (csr_chan.valid) begin
         case (csr_index_type'(csr_chan.index))
            CSR_BOX_X:   box_ff[0]  <= BOX_W'(csr_chan.data);
            CSR_BOX_Y:   box_ff[1]  <= BOX_W'(csr_chan.data);
            CSR_BOX_Z:   box_ff[2]  <= BOX_W'(csr_chan.data);
            CSR_MIN_COS: min_cos_ff <= COS_W'(csr_chan.data);
            default: begin
            end
         endcase
      end
   end

   assign csr_chan.ready = 1'b1;

   // The whole pipeline advances together. It only holds when the response
   // register carries a transaction that the sink has not yet taken, so an
   // empty response register lets a new request in on the same cycle.
   logic en;
   logic rsp_valid_ff;

   assign en             = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   coord_vec_type a_v, b_v, c_v, d_v;

   assign a_v[0] = req_chan.a_x;
   assign a_v[1] = req_chan.a_y;
   assign a_v[2] = req_chan.a_z;
   assign b_v[0] = req_chan.b_x;
   assign b_v[1] = req_chan.b_y;
   assign b_v[2] = req_chan.b_z;
   assign c_v[0] = req_chan.c_x;
   assign c_v[1] = req_chan.c_y;
   assign c_v[2] = req_chan.c_z;
   assign d_v[0] = req_chan.d_x;
   assign d_v[1] = req_chan.d_y;
   assign d_v[2] = req_chan.d_z;

   // Edge vectors b-a, c-a and d-a, each wrapped once per axis.
   logic         edge_valid;
   edge_vec_type eb, ec, ed;

   pfac_wrap u_wrap (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_chan.valid),
      .a         (a_v),
      .b         (b_v),
      .c         (c_v),
      .d         (d_v),
      .box       (box_ff),
      .out_valid (edge_valid),
      .eb        (eb),
      .ec        (ec),
      .ed        (ed)
   );

   // Face (a,b,c) uses edges b-a then c-a; face (a,d,b) uses d-a then b-a.
   // Both units have the same depth, so their results line up.
   face_out_type face1, face2;

   pfac_face u_face1 (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (edge_valid),
      .e        (eb),
      .f        (ec),
      .res      (face1)
   );

   pfac_face u_face2 (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (edge_valid),
      .e        (ed),
      .f        (eb),
      .res      (face2)
   );

   // Products of the unit normal components, in Q4.28.
   logic                    t1_valid_ff;
   logic                    t1_deg_ff;
   logic signed [DOT_W-1:0] t1_prod_ff [3];
   logic signed [DOT_W-1:0] t1_prod_in [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         t1_prod_in[k] = $signed(face1.u[k]) * $signed(face2.u[k]);
      end
   end

   // Dot product rounded to Q2.14 and saturated to plus or minus one. A face
   // without area has no normal; such a pair is reported as degenerate and
   // as acceptable, with a cosine of zero.
   logic                    ok_in;
   logic signed [COS_W-1:0] cos_in;

   always_comb begin
      logic signed [DOT_W-1:0] sum;
      logic signed [DOT_W-1:0] c;
      sum = t1_prod_ff[0] + t1_prod_ff[1] + t1_prod_ff[2] + DOT_W'(ROUND_BIAS);
      c   = sum >>> FRAC_Q14;
      if (c > DOT_W'(UNIT_Q14)) begin
         c = DOT_W'(UNIT_Q14);
      end else if (c < -DOT_W'(UNIT_Q14)) begin
         c = -DOT_W'(UNIT_Q14);
      end
      if (t1_deg_ff) begin
         cos_in = '0;
         ok_in  = 1'b1;
      end else begin
         cos_in = COS_W'(c);
         ok_in  = (COS_W'(c) >= min_cos_ff);
      end
   end

   // The response register doubles as the last pipeline stage.
   logic                    ok_ff;
   logic signed [COS_W-1:0] cos_ff;
   logic                    deg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         t1_valid_ff  <= face1.valid && face2.valid;
         rsp_valid_ff <= t1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t1_prod_ff <= t1_prod_in;
         t1_deg_ff  <= face1.zero || face2.zero;
         ok_ff      <= ok_in;
         cos_ff     <= cos_in;
         deg_ff     <= t1_deg_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.angle_ok      = ok_ff;
   assign rsp_chan.normal_cosine = cos_ff;
   assign rsp_chan.degenerate    = deg_ff;

endmodule

### tb/periodic_face_angle_check_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// periodic_face_angle_check_test
// Drives face pairs into the fold check under several box and cosine settings
// and compares each response with a bit-accurate model of the fixed-point math.
// ----------------------------------------------------------------------------
module periodic_face_angle_check_test;
   import pfac_pkg::*;

   typedef struct {
      logic       angle_ok;
      logic [15:0] normal_cosine;
      logic       degenerate;
   } fold_result_type;

   // Keeps the expected responses in arrival order and checks each one.
   class fold_scoreboard;
      fold_result_type pending[$];
      int              errors = 0;

      function void note_request(fold_result_type r);
         pending.insert(pending.size(), r);
      endfunction

      function void check_response(logic ok, logic [15:0] cosv, logic degen);
         fold_result_type e;
         if (pending.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
            return;
         end
         e = pending.pop_front();
         if (ok !== e.angle_ok) begin
            $error("angle_ok expected %0b actual %0b", e.angle_ok, ok);
            errors++;
         end
         if (cosv !== e.normal_cosine) begin
            $error("normal_cosine expected %0d actual %0d",
                   $signed(e.normal_cosine), $signed(cosv));
            errors++;
         end
         if (degen !== e.degenerate) begin
            $error("degenerate expected %0b actual %0b", e.degenerate, degen);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #2 clock = ~clock;

   pfac_req_if req_chan();
   pfac_rsp_if rsp_chan();
   pfac_csr_if csr_chan();

   periodic_face_angle_check u_top (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source),
      .csr_chan(csr_chan.sink)
   );

   // Shadow copy of the configuration registers.
   longint unsigned box_len[3];
   longint          min_cos;

   fold_scoreboard board = new();
   bit              long_hold = 1'b0;
   int              idle_cycles = 0;

   localparam int IDLE_LIMIT = 20000;

   // Arithmetic shift right, rounding toward minus infinity.
   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint unsigned magnitude(longint v);
      return v < 0 ? longint'(0) - v : v;
   endfunction

   // Apply one minimum-image shift when the component spans over half the box.
   function automatic longint wrap_edge(longint d, longint unsigned box);
      if (2 * magnitude(d) > box) begin
         if (d < 0) d += longint'(box);
         else if (d > 0) d -= longint'(box);
      end
      return d;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // Unit normal of edges e and f in Q2.14; returns 0 for a zero-area face.
   function automatic bit face_normal(input longint e[3], input longint f[3],
                                      output longint u[3]);
      longint          p[3], q[3], n[3];
      longint unsigned m, sum, r, a;
      int              s;
      m = 0;
      sum = 0;
      s = 0;
      for (int i = 0; i < 3; i++) begin
         if (magnitude(e[i]) > m) m = magnitude(e[i]);
         if (magnitude(f[i]) > m) m = magnitude(f[i]);
      end
      while ((m >> s) > (64'd1 << 30)) s++;
      for (int i = 0; i < 3; i++) begin
         p[i] = floor_shift(e[i], s);
         q[i] = floor_shift(f[i], s);
      end
      n[0] = p[1] * q[2] - p[2] * q[1];
      n[1] = p[2] * q[0] - p[0] * q[2];
      n[2] = p[0] * q[1] - p[1] * q[0];
      m = 0;
      for (int i = 0; i < 3; i++)
         if (magnitude(n[i]) > m) m = magnitude(n[i]);
      if (m == 0) return 1'b0;
      if (m >= (64'd1 << 31)) begin
         s = 0;
         while ((m >> s) >= (64'd1 << 31)) s++;
         for (int i = 0; i < 3; i++) n[i] = floor_shift(n[i], s);
      end else begin
         s = 0;
         while ((m << s) < (64'd1 << 30)) s++;
         for (int i = 0; i < 3; i++) n[i] = n[i] * (longint'(1) << s);
      end
      for (int i = 0; i < 3; i++) sum += magnitude(n[i]) * magnitude(n[i]);
      r = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         a = (magnitude(n[i]) * UNIT_Q14 + r / 2) / r;
         if (a > UNIT_Q14) a = UNIT_Q14;
         u[i] = n[i] < 0 ? -longint'(a) : longint'(a);
      end
      return 1'b1;
   endfunction

   // Expected response for corner positions a, b, c, d (x, y, z each).
   function automatic fold_result_type predict_fold(input longint pa[3],
         input longint pb[3], input longint pc[3], input longint pd[3]);
      fold_result_type res;
      longint          eb[3], ec[3], ed[3], u1[3], u2[3];
      longint          dot, cosv;
      bit              ok1, ok2;
      for (int i = 0; i < 3; i++) begin
         eb[i] = wrap_edge(pb[i] - pa[i], box_len[i]);
         ec[i] = wrap_edge(pc[i] - pa[i], box_len[i]);
         ed[i] = wrap_edge(pd[i] - pa[i], box_len[i]);
      end
      ok1 = face_normal(eb, ec, u1);
      ok2 = face_normal(ed, eb, u2);
      if (!ok1 || !ok2) begin
         res.angle_ok = 1'b1;
         res.normal_cosine = '0;
         res.degenerate = 1'b1;
         return res;
      end
      dot = 0;
      for (int i = 0; i < 3; i++) dot += u1[i] * u2[i];
      cosv = floor_shift(dot + ROUND_BIAS, 14);
      if (cosv > UNIT_Q14) cosv = UNIT_Q14;
      if (cosv < -UNIT_Q14) cosv = -UNIT_Q14;
      res.angle_ok = cosv >= min_cos;
      res.normal_cosine = cosv[15:0];
      res.degenerate = 1'b0;
      return res;
   endfunction

   task automatic write_register(csr_index_type idx, logic [31:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      case (idx)
         CSR_BOX_X:   box_len[0] = 64'(value[30:0]);
         CSR_BOX_Y:   box_len[1] = 64'(value[30:0]);
         CSR_BOX_Z:   box_len[2] = 64'(value[30:0]);
         CSR_MIN_COS: min_cos = longint'($signed(value[15:0]));
         default: begin
         end
      endcase
   endtask

   task automatic set_config(logic [30:0] bx, logic [30:0] by, logic [30:0] bz,
                             logic [15:0] mc);
      write_register(CSR_BOX_X, {1'b0, bx});
      write_register(CSR_BOX_Y, {1'b0, by});
      write_register(CSR_BOX_Z, {1'b0, bz});
      write_register(CSR_MIN_COS, {16'h0, mc});
   endtask

   // Offer one transaction after a random gap; the expectation is noted at the
   // edge where it is accepted.
   task automatic send_faces(logic [31:0] v[12]);
      longint          pa[3], pb[3], pc[3], pd[3];
      int              gap;
      gap = $urandom_range(7);
      if ($urandom_range(3) == 0) gap = 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      for (int i = 0; i < 3; i++) begin
         pa[i] = $signed(v[i]);
         pb[i] = $signed(v[3 + i]);
         pc[i] = $signed(v[6 + i]);
         pd[i] = $signed(v[9 + i]);
      end
      req_chan.valid <= 1'b1;
      {req_chan.a_x, req_chan.a_y, req_chan.a_z} <= {v[0], v[1], v[2]};
      {req_chan.b_x, req_chan.b_y, req_chan.b_z} <= {v[3], v[4], v[5]};
      {req_chan.c_x, req_chan.c_y, req_chan.c_z} <= {v[6], v[7], v[8]};
      {req_chan.d_x, req_chan.d_y, req_chan.d_z} <= {v[9], v[10], v[11]};
      do @(posedge clock); while (!req_chan.ready);
      board.note_request(predict_fold(pa, pb, pc, pd));
   endtask

   task automatic end_burst();
      req_chan.valid <= 1'b0;
   endtask

   // Wait until every response is back, then let the pipeline drain.
   task automatic drain_pipeline();
      end_burst();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (70) @(posedge clock);
   endtask

   function automatic logic [31:0] random_coord(int mode);
      case (mode)
         0: return $urandom();
         1: return 32'($signed($urandom_range(1310720)) - 655360);
         default: return 32'($signed($urandom_range(40000)) - 20000);
      endcase
   endfunction

   // A mostly sensible face pair: small coordinates near a random center,
   // occasionally full-range noise or repeated corners to hit degeneracy.
   task automatic send_random_faces();
      logic [31:0] v[12];
      int          mode;
      logic [31:0] base[3];
      mode = $urandom_range(9);
      for (int i = 0; i < 3; i++) base[i] = $urandom();
      for (int i = 0; i < 12; i++) begin
         if (mode == 0) v[i] = $urandom();
         else if (mode < 4) v[i] = base[i % 3] + random_coord(1);
         else v[i] = base[i % 3] + random_coord(2);
      end
      if (mode == 9) begin
         for (int i = 0; i < 3; i++) v[6 + i] = v[i];
      end
      send_faces(v);
   endtask

   task automatic send_directed();
      logic [31:0] v[12];
      logic [31:0] corners[4][3];
      // Flat pair of unit triangles, then folded and opposed variants.
      corners = '{'{0, 0, 0}, '{65536, 0, 0}, '{0, 65536, 0}, '{0, -65536, 0}};
      for (int k = 0; k < 4; k++)
         for (int i = 0; i < 3; i++) v[k * 3 + i] = corners[k][i];
      send_faces(v);
      v[11] = 65536;
      send_faces(v);
      v[9] = 0; v[10] = 65536; v[11] = 0;
      send_faces(v);
      // Zero-area faces: repeated corner and collinear corners.
      v = '{0, 0, 0, 65536, 0, 0, 0, 0, 0, 0, 65536, 0};
      send_faces(v);
      v = '{0, 0, 0, 65536, 0, 0, 131072, 0, 0, 0, 65536, 0};
      send_faces(v);
      v = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
      send_faces(v);
      // Extreme coordinates, with edges far longer than the box.
      v = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 0, 0,
            0, 32'h7fffffff, 0, 0, 0, 32'h7fffffff};
      send_faces(v);
      v = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'hffffffff,
            1, 32'hffffffff, 32'h80000000, 0, 1, 0, 32'h80000000};
      send_faces(v);
      for (int i = 0; i < 12; i++) v[i] = (i % 2) ? 32'h80000000 : 32'h7fffffff;
      send_faces(v);
      // Edges just across half the box so the wrap kicks in.
      v = '{0, 0, 0, 360000, 0, 0, 0, 400000, 0, -360000, -400000, 100};
      send_faces(v);
      v = '{0, 0, 0, -327680, 1, 0, 1, -327681, 0, 0, 1, 327681};
      send_faces(v);
      // Nearly flat pair to probe cosine saturation at one.
      v = '{0, 0, 0, 32'h40000000, 0, 0, 0, 32'h40000000, 1, 0, 32'hc0000000, 1};
      send_faces(v);
   endtask

   // Watchdog on cycles with no accepted transaction on either channel.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("periodic_face_angle_check verification failed");
         $finish;
      end
   end

   // Response side: check every accepted transaction.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         board.check_response(rsp_chan.angle_ok, rsp_chan.normal_cosine,
                              rsp_chan.degenerate);
   end

   // Response back-pressure: random stalls, stretches of none, and one long
   // hold-off that fills the pipeline and stalls the request side.
   initial begin
      int stall;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_chan.ready <= 1'b0;
            repeat (400) @(posedge clock);
            long_hold = 1'b0;
         end
         stall = $urandom_range(7);
         if ($urandom_range(3) == 0) stall = 0;
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
      end
   end

   initial begin
      req_chan.valid <= 1'b0;
      {req_chan.a_x, req_chan.a_y, req_chan.a_z} <= '0;
      {req_chan.b_x, req_chan.b_y, req_chan.b_z} <= '0;
      {req_chan.c_x, req_chan.c_y, req_chan.c_z} <= '0;
      {req_chan.d_x, req_chan.d_y, req_chan.d_z} <= '0;
      csr_chan.valid <= 1'b0;
      csr_chan.index <= CSR_BOX_X;
      csr_chan.data  <= '0;
      box_len = '{655360, 655360, 655360};
      min_cos = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values first, then directed cases under other settings.
      send_directed();
      drain_pipeline();
      set_config(31'h7fffffff, 31'd1, 31'd0, 16'sd16384);
      send_directed();
      drain_pipeline();
      set_config(31'd262144, 31'd655360, 31'd1310720, -16'sd16384);
      send_directed();
      drain_pipeline();

      // Random phases through several box sizes and thresholds.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_config(31'd655360, 31'd655360, 31'd655360, 16'sd0);
            1: set_config(31'd131072, 31'd196608, 31'd65536, 16'sd11585);
            2: set_config(31'h7fffffff, 31'h7fffffff, 31'h7fffffff, -16'sd8192);
            3: set_config(31'($urandom()), 31'($urandom()), 31'($urandom()),
                          16'($signed($urandom_range(32768)) - 16384));
            4: set_config(31'($urandom_range(2000000)), 31'($urandom_range(2000000)),
                          31'($urandom_range(2000000)), 16'sd16384);
            default: set_config(31'd1, 31'd0, 31'd40000, -16'sd16384);
         endcase
         if (phase == 2) long_hold = 1'b1;
         repeat (170) send_random_faces();
         drain_pipeline();
      end

      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("periodic_face_angle_check verification clean");
      end else begin
         $display("periodic_face_angle_check verification failed");
      end
      $finish;
   end

endmodule

### sim.f
src/pfac_pkg.sv
src/pfac_ifs.sv
src/pfac_wrap.sv
src/pfac_sqrt.sv
src/pfac_div.sv
src/pfac_face.sv
src/periodic_face_angle_check.sv
tb/periodic_face_angle_check_test.sv
